@@ sv/pts_pkg.sv @@
// Shared types and constants for the per-flow byte shaper.
// No dependencies; imported by every module of the block.
package pts_pkg;

  localparam int QUEUE_DEPTH_D   = 32;
  localparam int TABLE_ENTRIES_D = 16;
  localparam int MAX_RELEASE     = 32;
  localparam int FIELD_W         = 16;
  localparam int USAGE_W         = 17;

  localparam logic [5:0] QLIMIT_RESET = 6'd32;

  // operation codes of an input item
  localparam logic [1:0] OP_ARRIVE = 2'd0;
  localparam logic [1:0] OP_ENTRY  = 2'd1;
  localparam logic [1:0] OP_TICK   = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_KEY_MODE    = 2'd0;
  localparam logic [1:0] CFG_QUEUE_LIMIT = 2'd1;

  typedef enum logic [2:0] {
    ST_QUEUED       = 3'd0,
    ST_DROPPED      = 3'd1,
    ST_REGISTERED   = 3'd2,
    ST_DEREGISTERED = 3'd3,
    ST_UNKNOWN      = 3'd4,
    ST_RELEASED     = 3'd5,
    ST_NONE         = 3'd6
  } status_t;

  typedef struct packed {
    logic [FIELD_W-1:0] handle;
    logic [FIELD_W-1:0] length;
    logic [FIELD_W-1:0] flow;
    logic [FIELD_W-1:0] recv;
  } desc_t;

endpackage

@@ sv/pts_fifo_mem.sv @@
// Descriptor store: one write port, one read port, registered read data.
// Depends on pts_pkg for the descriptor type.
module pts_fifo_mem
  import pts_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_D,
  parameter int AW    = 5
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  desc_t         wr_data,
  input  logic [AW-1:0] rd_addr,
  output desc_t         rd_data
);

  desc_t mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

@@ sv/per_flow_tti_byte_shaper.sv @@
// Top level of the per-flow byte shaper: control sequencer and entry table.
// Depends on pts_pkg and pts_fifo_mem.
//
// Usage:
//   An item is taken when start is high and busy is low. Packet arrivals give
//   one result in the next cycle and leave busy low, so arrivals can follow
//   back to back. A register item that adds or updates an entry also answers
//   in the next cycle.
//   A tick or a deregister walks the descriptor queue in order, taking each
//   queued descriptor through a memory read state, then a decide state that
//   writes it back at the tail if it stays. A tick then runs a usage decay
//   state and a closing result state; a deregister runs only the closing
//   state. busy stays high for the whole walk.
//   Results appear on the out_ ports for one cycle with out_valid high; the
//   final result of an item has out_last set. A released packet of a tick is
//   held until the walk finds the next released one and comes out then; the
//   last one is held back until the walk ends so that it carries out_last.
//   Configuration writes go through cfg_valid/cfg_ready; cfg_ready is high
//   while the block is idle.
//   Reset empties the queue, invalidates every entry, sets key_mode to 0 and
//   queue_limit to 32. The receiver cannot stall; results are never held.
module per_flow_tti_byte_shaper
  import pts_pkg::*;
#(
  parameter int QUEUE_DEPTH   = QUEUE_DEPTH_D,
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_D
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_operation,
  input  logic [FIELD_W-1:0] in_packet_handle,
  input  logic [FIELD_W-1:0] in_packet_length,
  input  logic [FIELD_W-1:0] in_flow_id,
  input  logic [FIELD_W-1:0] in_receiver_id,
  input  logic [FIELD_W-1:0] in_entry_key,
  input  logic [FIELD_W-1:0] in_byte_budget,
  output logic               out_valid,
  output logic [2:0]         out_status,
  output logic [FIELD_W-1:0] out_packet_handle,
  output logic [FIELD_W-1:0] out_length,
  output logic [FIELD_W-1:0] out_flow_id,
  output logic [FIELD_W-1:0] out_receiver_id,
  output logic               out_last,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [5:0]         cfg_data
);

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int SW = CW + 1;
  localparam int EW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int RW = $clog2(MAX_RELEASE + 1);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_RD    = 5'b00010,
    S_EV    = 5'b00100,
    S_DECAY = 5'b01000,
    S_FIN   = 5'b10000
  } state_t;

  state_t             state_r;
  logic               key_mode_r;
  logic [5:0]         qlimit_r;
  logic [AW-1:0]      head_r;
  logic [CW-1:0]      count_r;
  logic [CW-1:0]      rem_r;
  logic               is_tick_r;
  logic [FIELD_W-1:0] pkey_r;
  logic [EW-1:0]      pidx_r;
  logic [RW-1:0]      rel_cnt_r;
  logic               pend_valid_r;
  desc_t              pend_r;

  logic [TABLE_ENTRIES-1:0] valid_r;
  logic [FIELD_W-1:0]       key_r    [TABLE_ENTRIES];
  logic [FIELD_W-1:0]       budget_r [TABLE_ENTRIES];
  logic [USAGE_W-1:0]       usage_r  [TABLE_ENTRIES];

  logic               out_valid_r;
  logic               out_valid_nxt;
  status_t            out_status_r;
  desc_t              out_desc_r;
  logic               out_last_r;

  desc_t              in_desc;
  desc_t              rd_data;
  logic               accept;
  logic [FIELD_W-1:0] lk_key;
  logic [FIELD_W-1:0] rd_key;
  logic               hit;
  logic [EW-1:0]      hidx;
  logic               free_any;
  logic [EW-1:0]      fidx;
  logic [SW-1:0]      tail_sum;
  logic [AW-1:0]      tail;
  logic [AW-1:0]      head_inc;
  logic               room;
  logic               eligible;
  logic               wr_en;

  assign accept    = start && !busy;
  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = !busy;

  assign in_desc = '{handle: in_packet_handle, length: in_packet_length,
                     flow: in_flow_id, recv: in_receiver_id};

  // key of the descriptor under the current mode
  assign rd_key = key_mode_r ? rd_data.recv : rd_data.flow;
  assign lk_key = (state_r == S_IDLE) ? in_entry_key : rd_key;

  // table lookup and first free entry, lowest index wins
  always_comb begin
    hit      = 1'b0;
    hidx     = '0;
    free_any = 1'b0;
    fidx     = '0;
    for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
      if (valid_r[i] && key_r[i] == lk_key) begin
        hit  = 1'b1;
        hidx = EW'(i);
      end
      if (!valid_r[i]) begin
        free_any = 1'b1;
        fidx     = EW'(i);
      end
    end
  end

  // queue pointer arithmetic
  assign tail_sum = SW'(head_r) + SW'(count_r);
  assign tail     = (tail_sum >= SW'(QUEUE_DEPTH)) ? AW'(tail_sum - SW'(QUEUE_DEPTH))
                                                   : AW'(tail_sum);
  assign head_inc = (head_r == AW'(QUEUE_DEPTH - 1)) ? '0 : AW'(head_r + 1'b1);
  assign room     = (count_r < CW'(QUEUE_DEPTH)) && (8'(count_r) < 8'(qlimit_r));

  // release test for a tick
  assign eligible = hit && (usage_r[hidx] < USAGE_W'(budget_r[hidx]))
                    && (rel_cnt_r < RW'(MAX_RELEASE));

  // write at tail: arrival with room, or requeue during a walk
  always_comb begin
    wr_en = 1'b0;
    if (accept && in_operation == OP_ARRIVE && room) begin
      wr_en = 1'b1;
    end else if (state_r == S_EV) begin
      wr_en = is_tick_r ? !eligible : (rd_key != pkey_r);
    end
  end

  // result strobe for the next cycle
  always_comb begin
    out_valid_nxt = 1'b0;
    if (state_r == S_IDLE) begin
      out_valid_nxt = accept && (in_operation != OP_TICK)
                      && !(in_operation == OP_ENTRY && in_byte_budget == '0 && hit);
    end else if (state_r == S_EV) begin
      out_valid_nxt = is_tick_r && eligible && pend_valid_r;
    end else if (state_r == S_FIN) begin
      out_valid_nxt = 1'b1;
    end
  end

  pts_fifo_mem #(
    .DEPTH (QUEUE_DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (tail),
    .wr_data ((state_r == S_IDLE) ? in_desc : rd_data),
    .rd_addr (head_r),
    .rd_data (rd_data)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_mode_r <= 1'b0;
      qlimit_r   <= QLIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_KEY_MODE:    key_mode_r <= cfg_data[0];
        CFG_QUEUE_LIMIT: qlimit_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // entry table payload
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && accept && in_operation == OP_ENTRY
        && in_byte_budget != '0 && (hit || free_any)) begin
      key_r[hit ? hidx : fidx]    <= in_entry_key;
      budget_r[hit ? hidx : fidx] <= in_byte_budget;
      usage_r[hit ? hidx : fidx]  <= '0;
    end else if (state_r == S_EV && is_tick_r && eligible) begin
      usage_r[hidx] <= USAGE_W'(usage_r[hidx] + USAGE_W'(rd_data.length));
    end else if (state_r == S_DECAY) begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        if (valid_r[i] && usage_r[i] != '0) begin
          usage_r[i] <= (usage_r[i] > USAGE_W'(budget_r[i]))
                        ? USAGE_W'(usage_r[i] - USAGE_W'(budget_r[i])) : '0;
        end
      end
    end else if (state_r == S_FIN && !is_tick_r) begin
      budget_r[pidx_r] <= '0;
      usage_r[pidx_r]  <= '0;
    end
  end

  // sequencer, queue pointers, valid bits and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      head_r       <= '0;
      count_r      <= '0;
      rem_r        <= '0;
      is_tick_r    <= 1'b0;
      rel_cnt_r    <= '0;
      pend_valid_r <= 1'b0;
      valid_r      <= '0;
      out_valid_r  <= 1'b0;
      out_last_r   <= 1'b0;
      out_status_r <= ST_NONE;
      out_desc_r   <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            out_last_r <= 1'b1;
            out_desc_r <= (in_operation == OP_ARRIVE) ? in_desc : '0;
            case (in_operation)
              OP_ARRIVE: begin
                out_status_r <= room ? ST_QUEUED : ST_DROPPED;
                if (room) begin
                  count_r <= CW'(count_r + 1'b1);
                end
              end
              OP_ENTRY: begin
                if (in_byte_budget == '0) begin
                  if (hit) begin
                    is_tick_r <= 1'b0;
                    pkey_r    <= in_entry_key;
                    pidx_r    <= hidx;
                    rem_r     <= count_r;
                    state_r   <= (count_r != '0) ? S_RD : S_FIN;
                  end else begin
                    out_status_r <= ST_UNKNOWN;
                  end
                end else begin
                  out_status_r <= (hit || free_any) ? ST_REGISTERED : ST_UNKNOWN;
                  if (hit || free_any) begin
                    valid_r[hit ? hidx : fidx] <= 1'b1;
                  end
                end
              end
              OP_TICK: begin
                is_tick_r    <= 1'b1;
                rem_r        <= count_r;
                rel_cnt_r    <= '0;
                pend_valid_r <= 1'b0;
                state_r      <= (count_r != '0) ? S_RD : S_DECAY;
              end
              default: begin
                out_status_r <= ST_UNKNOWN;
              end
            endcase
          end
        end
        S_RD: begin
          state_r <= S_EV;
        end
        S_EV: begin
          // pop the head; requeue write was issued at the tail above
          head_r <= head_inc;
          rem_r  <= CW'(rem_r - 1'b1);
          if (!wr_en) begin
            count_r <= CW'(count_r - 1'b1);
          end
          if (is_tick_r && eligible) begin
            rel_cnt_r    <= RW'(rel_cnt_r + 1'b1);
            pend_valid_r <= 1'b1;
            pend_r       <= rd_data;
            if (pend_valid_r) begin
              out_last_r   <= 1'b0;
              out_status_r <= ST_RELEASED;
              out_desc_r   <= pend_r;
            end
          end
          if (rem_r == CW'(1)) begin
            state_r <= is_tick_r ? S_DECAY : S_FIN;
          end else begin
            state_r <= S_RD;
          end
        end
        S_DECAY: begin
          state_r <= S_FIN;
        end
        S_FIN: begin
          out_last_r  <= 1'b1;
          if (is_tick_r) begin
            out_status_r <= pend_valid_r ? ST_RELEASED : ST_NONE;
            out_desc_r   <= pend_valid_r ? pend_r : '0;
            pend_valid_r <= 1'b0;
          end else begin
            out_status_r    <= ST_DEREGISTERED;
            out_desc_r      <= '0;
            valid_r[pidx_r] <= 1'b0;
          end
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_packet_handle = out_desc_r.handle;
  assign out_length        = out_desc_r.length;
  assign out_flow_id       = out_desc_r.flow;
  assign out_receiver_id   = out_desc_r.recv;
  assign out_last          = out_last_r;

endmodule

@@ sv/pts_checker.sv @@
// Port-level checks for the per-flow byte shaper, bound to the top level.
// Depends on pts_pkg for status and operation codes.
module pts_checker
  import pts_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic [1:0]         in_operation,
  input logic               out_valid,
  input logic [2:0]         out_status,
  input logic [FIELD_W-1:0] out_packet_handle,
  input logic               out_last
);

  // an arrival answers in the next cycle as its only result
  a_arrive_answer: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_operation == OP_ARRIVE |=>
      out_valid && out_last && (out_status == ST_QUEUED || out_status == ST_DROPPED))
    else $error("arrival not answered in next cycle");

  // statuses without a packet carry zero payload
  a_zero_payload: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_REGISTERED || out_status == ST_DEREGISTERED ||
                  out_status == ST_UNKNOWN || out_status == ST_NONE)
      |-> out_packet_handle == '0)
    else $error("payload on a status without packet");

  // non-release results always close their item
  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_RELEASED |-> out_last)
    else $error("non-release result without last");

  // reset leaves the block idle and quiet
  a_reset_idle: assert property (@(posedge clk)
    $past(!rst_n) |-> !busy && !out_valid)
    else $error("block not idle after reset");

endmodule

bind per_flow_tti_byte_shaper pts_checker u_pts_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .start             (start),
  .busy              (busy),
  .in_operation      (in_operation),
  .out_valid         (out_valid),
  .out_status        (out_status),
  .out_packet_handle (out_packet_handle),
  .out_last          (out_last)
);

@@ bench/per_flow_tti_byte_shaper_chk.sv @@
// Checker for the per-flow byte shaper: watches the item, result and config
// channels, predicts every result and compares. Depends on pts_pkg.
module per_flow_tti_byte_shaper_chk
  import pts_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  logic [1:0]         in_operation,
  input  logic [FIELD_W-1:0] in_packet_handle,
  input  logic [FIELD_W-1:0] in_packet_length,
  input  logic [FIELD_W-1:0] in_flow_id,
  input  logic [FIELD_W-1:0] in_receiver_id,
  input  logic [FIELD_W-1:0] in_entry_key,
  input  logic [FIELD_W-1:0] in_byte_budget,
  input  logic               out_valid,
  input  logic [2:0]         out_status,
  input  logic [FIELD_W-1:0] out_packet_handle,
  input  logic [FIELD_W-1:0] out_length,
  input  logic [FIELD_W-1:0] out_flow_id,
  input  logic [FIELD_W-1:0] out_receiver_id,
  input  logic               out_last,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [5:0]         cfg_data,
  output int                 fail_count,
  output int                 pending,
  output int                 items_seen,
  output int                 released_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    status_t            status;
    desc_t              pkt;
    logic               last;
  } shaper_result_t;

  shaper_result_t      expected_results[$];
  desc_t               queued_pkts[$];
  logic                slot_valid  [TABLE_ENTRIES_D];
  logic [FIELD_W-1:0]  slot_key    [TABLE_ENTRIES_D];
  logic [FIELD_W-1:0]  slot_budget [TABLE_ENTRIES_D];
  logic [USAGE_W-1:0]  slot_usage  [TABLE_ENTRIES_D];
  logic                mode_recv;
  logic [5:0]          limit_reg;

  assign pending = expected_results.size();

  task automatic report(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    fail_count++;
  endtask

  function automatic logic [FIELD_W-1:0] key_of(input desc_t d);
    return mode_recv ? d.recv : d.flow;
  endfunction

  function automatic int lookup_slot(input logic [FIELD_W-1:0] key);
    for (int i = 0; i < TABLE_ENTRIES_D; i++)
      if (slot_valid[i] && slot_key[i] == key) return i;
    return -1;
  endfunction

  // compute the results of one accepted item and advance the shadow state
  function automatic void shape_item(input logic [1:0] op, input desc_t pk,
                                     input logic [FIELD_W-1:0] key,
                                     input logic [FIELD_W-1:0] budget);
    shaper_result_t outs[$];
    shaper_result_t r;
    desc_t          none;
    desc_t          d;
    int             e;
    int             n;
    int             lim;
    none = '0;
    r.last = 1'b0;
    r.pkt = none;
    case (op)
      OP_ARRIVE: begin
        lim = (limit_reg < QUEUE_DEPTH_D) ? limit_reg : QUEUE_DEPTH_D;
        r.pkt = pk;
        if (queued_pkts.size() < lim) begin
          queued_pkts.push_back(pk);
          r.status = ST_QUEUED;
        end else begin
          r.status = ST_DROPPED;
        end
        outs.push_back(r);
      end
      OP_ENTRY: begin
        e = lookup_slot(key);
        if (budget == 0) begin
          if (e < 0) begin
            r.status = ST_UNKNOWN;
          end else begin
            n = queued_pkts.size();
            for (int i = 0; i < n; i++) begin
              d = queued_pkts.pop_front();
              if (key_of(d) != key) queued_pkts.push_back(d);
            end
            slot_valid[e] = 1'b0;
            slot_budget[e] = '0;
            slot_usage[e] = '0;
            r.status = ST_DEREGISTERED;
          end
        end else begin
          if (e < 0)
            for (int i = TABLE_ENTRIES_D - 1; i >= 0; i--)
              if (!slot_valid[i]) e = i;
          if (e < 0) begin
            r.status = ST_UNKNOWN;
          end else begin
            slot_valid[e] = 1'b1;
            slot_key[e] = key;
            slot_budget[e] = budget;
            slot_usage[e] = '0;
            r.status = ST_REGISTERED;
          end
        end
        outs.push_back(r);
      end
      OP_TICK: begin
        n = queued_pkts.size();
        for (int i = 0; i < n; i++) begin
          d = queued_pkts.pop_front();
          e = lookup_slot(key_of(d));
          if (e >= 0 && slot_usage[e] < {1'b0, slot_budget[e]}
              && outs.size() < MAX_RELEASE) begin
            slot_usage[e] = slot_usage[e] + d.length;
            r.status = ST_RELEASED;
            r.pkt = d;
            outs.push_back(r);
          end else begin
            queued_pkts.push_back(d);
          end
        end
        // usage decay, floored at zero
        for (int i = 0; i < TABLE_ENTRIES_D; i++)
          if (slot_valid[i] && slot_usage[i] != 0) begin
            if (slot_usage[i] > {1'b0, slot_budget[i]})
              slot_usage[i] = slot_usage[i] - slot_budget[i];
            else
              slot_usage[i] = '0;
          end
        if (outs.size() == 0) begin
          r.status = ST_NONE;
          r.pkt = none;
          outs.push_back(r);
        end
      end
      default: begin
        r.status = ST_UNKNOWN;
        outs.push_back(r);
      end
    endcase
    outs[outs.size() - 1].last = 1'b1;
    foreach (outs[i]) expected_results.push_back(outs[i]);
  endfunction

  always @(posedge clk) begin
    shaper_result_t x;
    desc_t          pk;
    if (!rst_n) begin
      expected_results.delete();
      queued_pkts.delete();
      for (int i = 0; i < TABLE_ENTRIES_D; i++) begin
        slot_valid[i] = 1'b0;
        slot_key[i] = '0;
        slot_budget[i] = '0;
        slot_usage[i] = '0;
      end
      mode_recv = 1'b0;
      limit_reg = QLIMIT_RESET;
    end else begin
      // config writes
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_KEY_MODE) mode_recv = cfg_data[0];
        else if (cfg_index == CFG_QUEUE_LIMIT) limit_reg = cfg_data;
      end
      // accepted item
      if (start && !busy) begin
        pk.handle = in_packet_handle;
        pk.length = in_packet_length;
        pk.flow = in_flow_id;
        pk.recv = in_receiver_id;
        shape_item(in_operation, pk, in_entry_key, in_byte_budget);
        items_seen++;
      end
      // result compare
      if (out_valid) begin
        if (expected_results.size() == 0) begin
          report($sformatf("unexpected result status %0d", out_status));
        end else begin
          x = expected_results.pop_front();
          if (out_status != x.status)
            report($sformatf("status %0d, want %0d", out_status, x.status));
          if (out_packet_handle != x.pkt.handle)
            report($sformatf("handle %h, want %h", out_packet_handle, x.pkt.handle));
          if (out_length != x.pkt.length)
            report($sformatf("length %h, want %h", out_length, x.pkt.length));
          if (out_flow_id != x.pkt.flow)
            report($sformatf("flow %h, want %h", out_flow_id, x.pkt.flow));
          if (out_receiver_id != x.pkt.recv)
            report($sformatf("receiver %h, want %h", out_receiver_id, x.pkt.recv));
          if (out_last != x.last)
            report($sformatf("last %0d, want %0d", out_last, x.last));
          if (x.status == ST_RELEASED) released_seen++;
        end
      end
    end
  end

  initial begin
    fail_count = 0;
    items_seen = 0;
    released_seen = 0;
  end

endmodule

@@ bench/per_flow_tti_byte_shaper_tb.sv @@
// Testbench top for the per-flow byte shaper: clock, reset, stimulus, verdict.
// Depends on pts_pkg, the shaper RTL and per_flow_tti_byte_shaper_chk.
module per_flow_tti_byte_shaper_tb;
  import pts_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] OP_INVALID = 2'd3;
  localparam int CYCLE_LIMIT = 300000;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [1:0]         in_operation = OP_ARRIVE;
  logic [FIELD_W-1:0] in_packet_handle = '0;
  logic [FIELD_W-1:0] in_packet_length = '0;
  logic [FIELD_W-1:0] in_flow_id = '0;
  logic [FIELD_W-1:0] in_receiver_id = '0;
  logic [FIELD_W-1:0] in_entry_key = '0;
  logic [FIELD_W-1:0] in_byte_budget = '0;
  logic               out_valid;
  logic [2:0]         out_status;
  logic [FIELD_W-1:0] out_packet_handle;
  logic [FIELD_W-1:0] out_length;
  logic [FIELD_W-1:0] out_flow_id;
  logic [FIELD_W-1:0] out_receiver_id;
  logic               out_last;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [1:0]         cfg_index = CFG_KEY_MODE;
  logic [5:0]         cfg_data = '0;
  int                 fail_count;
  int                 pending;
  int                 items_seen;
  int                 released_seen;
  int                 cycles = 0;
  logic [FIELD_W-1:0] key_pool [20];

  always #5 clk = ~clk;

  per_flow_tti_byte_shaper u_dut (.*);

  per_flow_tti_byte_shaper_chk u_chk (.*);

  // run watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("** per_flow_tti_byte_shaper: FAILED **");
      $finish;
    end
  end

  // one item: random gap, then hold start until the block takes it
  task automatic send_item(input logic [1:0] op, input logic [FIELD_W-1:0] handle,
                           input logic [FIELD_W-1:0] len, input logic [FIELD_W-1:0] flow,
                           input logic [FIELD_W-1:0] recv, input logic [FIELD_W-1:0] key,
                           input logic [FIELD_W-1:0] budget, input bit no_gap);
    int gap;
    gap = (no_gap || $urandom_range(3) == 0) ? 0 : $urandom_range(6);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_operation <= op;
    in_packet_handle <= handle;
    in_packet_length <= len;
    in_flow_id <= flow;
    in_receiver_id <= recv;
    in_entry_key <= key;
    in_byte_budget <= budget;
    do @(posedge clk); while (busy);
  endtask

  task automatic arrive(input logic [FIELD_W-1:0] flow, input logic [FIELD_W-1:0] recv,
                        input logic [FIELD_W-1:0] len);
    send_item(OP_ARRIVE, FIELD_W'($urandom), len, flow, recv,
              FIELD_W'($urandom), FIELD_W'($urandom), 1'b0);
  endtask

  task automatic entry(input logic [FIELD_W-1:0] key, input logic [FIELD_W-1:0] budget);
    send_item(OP_ENTRY, FIELD_W'($urandom), FIELD_W'($urandom), FIELD_W'($urandom),
              FIELD_W'($urandom), key, budget, 1'b0);
  endtask

  task automatic tick();
    send_item(OP_TICK, FIELD_W'($urandom), FIELD_W'($urandom), FIELD_W'($urandom),
              FIELD_W'($urandom), FIELD_W'($urandom), FIELD_W'($urandom), 1'b0);
  endtask

  // sender holds off until every expected result is back
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (pending != 0 || busy);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [5:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [FIELD_W-1:0] pick_key();
    return ($urandom_range(9) == 0) ? FIELD_W'($urandom) : key_pool[$urandom_range(19)];
  endfunction

  function automatic logic [FIELD_W-1:0] pick_len();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      2: return FIELD_W'($urandom);
      default: return FIELD_W'($urandom_range(1500));
    endcase
  endfunction

  function automatic logic [FIELD_W-1:0] pick_budget();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      2: return 16'hFFFF;
      default: return FIELD_W'($urandom_range(1, 4000));
    endcase
  endfunction

  // random traffic for one setting
  task automatic random_phase(input int count);
    int sel;
    for (int i = 0; i < count; i++) begin
      sel = $urandom_range(99);
      if (sel < 60) arrive(pick_key(), pick_key(), pick_len());
      else if (sel < 78) entry(pick_key(), pick_budget());
      else if (sel < 96) tick();
      else send_item(OP_INVALID, FIELD_W'($urandom), FIELD_W'($urandom),
                     FIELD_W'($urandom), FIELD_W'($urandom), FIELD_W'($urandom),
                     FIELD_W'($urandom), 1'b1);
    end
  endtask

  initial begin
    foreach (key_pool[i]) key_pool[i] = (i == 0) ? 16'h0000 :
                                        (i == 1) ? 16'hFFFF : FIELD_W'($urandom);
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty tick, unknown deregister, extremes, key zero, bad op
    tick();
    entry(16'h1234, 16'h0000);
    entry(16'h0000, 16'hFFFF);
    entry(16'hFFFF, 16'h0001);
    arrive(16'h0000, 16'hFFFF, 16'hFFFF);
    arrive(16'hFFFF, 16'h0000, 16'h0000);
    arrive(16'hFFFF, 16'h5A5A, 16'h0010);
    arrive(16'h4321, 16'hA5A5, 16'h0020);
    tick();
    tick();
    send_item(OP_INVALID, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
              16'hFFFF, 1'b1);
    entry(16'h4321, 16'h0000);
    entry(16'hFFFF, 16'h0000);
    entry(16'h0000, 16'h0000);
    drain();

    // full queue and release cap: one entry, 34 zero-length packets
    write_reg(CFG_QUEUE_LIMIT, 6'd63);
    entry(16'h00AA, 16'hFFFF);
    for (int i = 0; i < 34; i++) send_item(OP_ARRIVE, FIELD_W'(i), 16'h0000, 16'h00AA,
                                           FIELD_W'($urandom), 16'h0, 16'h0, 1'b1);
    tick();
    drain();

    // fill the table past its size
    for (int i = 0; i < TABLE_ENTRIES_D + 1; i++) entry(FIELD_W'(16'h0100 + i), 16'd50);
    drain();

    // random phases across settings, receiver keyed and flow keyed
    write_reg(CFG_KEY_MODE, 6'd1);
    write_reg(CFG_QUEUE_LIMIT, 6'd5);
    random_phase(20);
    drain();
    write_reg(CFG_QUEUE_LIMIT, 6'd0);
    random_phase(10);
    drain();
    write_reg(CFG_KEY_MODE, 6'd0);
    write_reg(CFG_QUEUE_LIMIT, 6'd32);
    random_phase(35);
    drain();
    write_reg(CFG_KEY_MODE, 6'd1);
    write_reg(CFG_QUEUE_LIMIT, 6'd1);
    random_phase(15);
    drain();
    write_reg(CFG_KEY_MODE, 6'd0);
    write_reg(CFG_QUEUE_LIMIT, 6'd63);
    random_phase(35);

    // settle
    start <= 1'b0;
    do @(posedge clk); while (pending != 0 || busy);
    repeat (10) @(posedge clk);

    $display("run covered %0d items, %0d packets released, %0d cycles",
             items_seen, released_seen, cycles);
    $display("both key modes and queue limits 0, 1, 5, 32, 63 were exercised");
    if (fail_count == 0) begin
      $display("** per_flow_tti_byte_shaper: PASSED **");
    end else begin
      $display("** per_flow_tti_byte_shaper: FAILED **");
    end
    $finish;
  end

endmodule

@@ per_flow_tti_byte_shaper.f @@
sv/pts_pkg.sv
sv/pts_fifo_mem.sv
sv/per_flow_tti_byte_shaper.sv
sv/pts_checker.sv
bench/per_flow_tti_byte_shaper_chk.sv
bench/per_flow_tti_byte_shaper_tb.sv
